FILE: rtl/scl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scl_pkg
// Shared types and constants for the servo command line parser.
// ----------------------------------------------------------------------------
package scl_pkg;

  localparam int LINE_CAPACITY = 24;
  localparam int LINE_MAX      = LINE_CAPACITY - 1;
  localparam int CNT_W         = $clog2(LINE_CAPACITY);

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CH_UC_S  = 8'h53;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [CNT_W-1:0] DEBUG_LEN = CNT_W'(5);
  localparam logic [CNT_W-1:0] RUN_LEN   = CNT_W'(3);

  localparam logic [7:0] ID_MAX    = 8'd4;
  localparam logic [7:0] ANGLE_MAX = 8'd180;
  localparam logic [7:0] NUM_SAT   = 8'd255;
  localparam logic [2:0] DEBUG_IDX = 3'd3;

  typedef enum logic [2:0] {
    RESP_DEBUG  = 3'd0,
    RESP_RUN    = 3'd1,
    RESP_SET_OK = 3'd2,
    RESP_ERROR  = 3'd3,
    RESP_LONG   = 3'd4
  } resp_e;

  typedef enum logic [2:0] {
    PH_HEAD0,
    PH_HEAD1,
    PH_ID_SP,
    PH_ID_DIG,
    PH_ANG_SP,
    PH_ANG_DIG,
    PH_TAIL,
    PH_BAD
  } phase_e;

  // word between the front and back: a folded printable byte or a line end
  typedef struct packed {
    logic       eol;
    logic [7:0] ch;
  } tok_t;

  typedef struct packed {
    resp_e      code;
    logic [2:0] idx;
    logic [7:0] deg;
    logic       dbg;
  } resp_t;

  function automatic logic [7:0] debug_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = "D";
      3'd1:    c = "E";
      3'd2:    c = "B";
      3'd3:    c = "U";
      3'd4:    c = "G";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] run_char(input logic [1:0] i);
    logic [7:0] c;
    case (i)
      2'd0:    c = "R";
      2'd1:    c = "U";
      2'd2:    c = "N";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/scl_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scl_front
// Classifies received bytes, folds case, drops control bytes and queues
// printable bytes and line ends for the back end.
// ----------------------------------------------------------------------------
module scl_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire logic [7:0]    rx_char_i,
  output logic               tok_valid_o,
  output scl_pkg::tok_t      tok_o,
  input  wire logic          tok_take_i
);
  import scl_pkg::*;

  tok_t       mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       is_eol, is_print, keep, wr_en, rd_en;
  tok_t       tok_new;

  always_comb begin
    is_eol   = (rx_char_i == CH_CR) || (rx_char_i == CH_LF);
    is_print = (rx_char_i >= CH_SPACE) && (rx_char_i <= CH_TILDE);
    keep     = is_eol || is_print;
    tok_new.eol = is_eol;
    if (rx_char_i >= CH_LC_A && rx_char_i <= CH_LC_Z) begin
      tok_new.ch = rx_char_i - CASE_OFS;
    end else begin
      tok_new.ch = rx_char_i;
    end
  end

  assign full        = (cnt_q == 2'd2);
  assign tok_valid_o = (cnt_q != 2'd0);
  assign tok_o       = mem_q[rd_q];

  always_comb begin
    wr_en = push && !full && keep;
    rd_en = tok_valid_o && tok_take_i;
    wr_d  = wr_q ^ wr_en;
    rd_d  = rd_q ^ rd_en;
    cnt_d = cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= tok_new;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/scl_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scl_back
// Per-byte incremental line matcher with a two-word response queue.
// ----------------------------------------------------------------------------
module scl_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          tok_valid_i,
  input  wire scl_pkg::tok_t tok_i,
  output logic               tok_take_o,
  output logic               empty,
  input  wire logic          pop,
  output logic [2:0]         resp_code_o,
  output logic [2:0]         servo_index_o,
  output logic [7:0]         servo_degrees_o,
  output logic               debug_mode_o
);
  import scl_pkg::*;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             long_q, long_d;
  logic             dbg_q, dbg_d;
  logic             mdbg_q, mdbg_d;
  logic             mrun_q, mrun_d;
  phase_e           ph_q, ph_d;
  logic [7:0]       id_q, id_d, ang_q, ang_d;

  resp_t            oq_q [2];
  logic             owr_q, ord_q;
  logic [1:0]       ocnt_q, ocnt_d;
  logic             produce, rd_en;
  resp_t            resp;
  logic             is_dig, is_sp, set_ok;
  logic [3:0]       dig;

  function automatic logic [7:0] acc_dig(input logic [7:0] a, input logic [3:0] d);
    logic [11:0] s;
    s = ({4'b0, a} * 12'd10) + {8'b0, d};
    return (s > {4'b0, NUM_SAT}) ? NUM_SAT : s[7:0];
  endfunction

  assign tok_take_o = tok_valid_i && (ocnt_q != 2'd2);

  always_comb begin
    is_dig = (tok_i.ch >= CH_ZERO) && (tok_i.ch <= CH_NINE);
    is_sp  = (tok_i.ch == CH_SPACE);
    dig    = tok_i.ch[3:0];
    set_ok = ((ph_q == PH_ANG_DIG) || (ph_q == PH_TAIL)) && dbg_q &&
             (id_q >= 8'd1) && (id_q <= ID_MAX) && (ang_q <= ANGLE_MAX);

    cnt_d   = cnt_q;
    long_d  = long_q;
    dbg_d   = dbg_q;
    mdbg_d  = mdbg_q;
    mrun_d  = mrun_q;
    ph_d    = ph_q;
    id_d    = id_q;
    ang_d   = ang_q;
    produce = 1'b0;
    resp.code = RESP_ERROR;
    resp.idx  = 3'd0;
    resp.deg  = 8'd0;
    resp.dbg  = dbg_q;

    if (tok_take_o) begin
      if (tok_i.eol || (!long_q && cnt_q == CNT_W'(LINE_MAX))) begin
        if (tok_i.eol) begin
          if (!long_q && cnt_q != '0) begin
            produce = 1'b1;
            if (mdbg_q && cnt_q == DEBUG_LEN) begin
              dbg_d     = 1'b1;
              resp.code = RESP_DEBUG;
              resp.idx  = DEBUG_IDX;
            end else if (dbg_q && mrun_q && cnt_q == RUN_LEN) begin
              dbg_d     = 1'b0;
              resp.code = RESP_RUN;
            end else if (set_ok) begin
              resp.code = RESP_SET_OK;
              resp.idx  = id_q[2:0];
              resp.deg  = ang_q;
            end
            resp.dbg = dbg_d;
          end
          long_d = 1'b0;
        end else begin
          produce   = 1'b1;
          long_d    = 1'b1;
          resp.code = RESP_LONG;
        end
        cnt_d  = '0;
        mdbg_d = 1'b1;
        mrun_d = 1'b1;
        ph_d   = PH_HEAD0;
        id_d   = 8'd0;
        ang_d  = 8'd0;
      end else if (!long_q) begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q < DEBUG_LEN) begin
          mdbg_d = mdbg_q && (tok_i.ch == debug_char(cnt_q[2:0]));
        end
        if (cnt_q < RUN_LEN) begin
          mrun_d = mrun_q && (tok_i.ch == run_char(cnt_q[1:0]));
        end
        case (ph_q)
          PH_HEAD0: ph_d = (tok_i.ch == CH_UC_S) ? PH_HEAD1 : PH_BAD;
          PH_HEAD1: ph_d = is_sp ? PH_ID_SP : PH_BAD;
          PH_ID_SP, PH_ID_DIG: begin
            if (is_dig) begin
              ph_d = PH_ID_DIG;
              id_d = acc_dig(id_q, dig);
            end else if (is_sp) begin
              ph_d = (ph_q == PH_ID_DIG) ? PH_ANG_SP : PH_ID_SP;
            end else begin
              ph_d = PH_BAD;
            end
          end
          PH_ANG_SP, PH_ANG_DIG: begin
            if (is_dig) begin
              ph_d  = PH_ANG_DIG;
              ang_d = acc_dig(ang_q, dig);
            end else if (is_sp) begin
              ph_d = (ph_q == PH_ANG_DIG) ? PH_TAIL : PH_ANG_SP;
            end else begin
              ph_d = PH_BAD;
            end
          end
          PH_TAIL: ph_d = is_sp ? PH_TAIL : PH_BAD;
          default: ph_d = PH_BAD;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      long_q <= 1'b0;
      dbg_q  <= 1'b0;
      mdbg_q <= 1'b1;
      mrun_q <= 1'b1;
      ph_q   <= PH_HEAD0;
      id_q   <= 8'd0;
      ang_q  <= 8'd0;
    end else begin
      cnt_q  <= cnt_d;
      long_q <= long_d;
      dbg_q  <= dbg_d;
      mdbg_q <= mdbg_d;
      mrun_q <= mrun_d;
      ph_q   <= ph_d;
      id_q   <= id_d;
      ang_q  <= ang_d;
    end
  end

  // response queue
  assign empty = (ocnt_q == 2'd0);
  assign rd_en = pop && !empty;

  always_comb begin
    ocnt_d = ocnt_q + {1'b0, produce} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= 1'b0;
      ord_q  <= 1'b0;
      ocnt_q <= 2'd0;
    end else begin
      owr_q  <= owr_q ^ produce;
      ord_q  <= ord_q ^ rd_en;
      ocnt_q <= ocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (produce) begin
      oq_q[owr_q] <= resp;
    end
  end

  assign resp_code_o     = oq_q[ord_q].code;
  assign servo_index_o   = oq_q[ord_q].idx;
  assign servo_degrees_o = oq_q[ord_q].deg;
  assign debug_mode_o    = oq_q[ord_q].dbg;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(LINE_MAX))
    else $error("line count out of range");

  a_long_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    long_q |-> (cnt_q == '0))
    else $error("overflowed line still holds characters");

  a_oq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ocnt_q != 2'd3) && !(produce && ocnt_q == 2'd2 && !rd_en))
    else $error("response queue overrun");

  a_set_needs_dbg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (produce && resp.code == RESP_SET_OK) |-> dbg_q)
    else $error("servo set accepted outside debug mode");

endmodule
`default_nettype wire

FILE: rtl/servo_command_line_parser_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// servo_command_line_parser_top
// Console line parser for debug, run and servo set commands.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, set by the single-byte matcher step, while
//   the response queue has room. A line-end or overflowing byte is queued in
//   the token queue, then its response word goes into the response queue.
// Reset: asynchronous, active low; clears both queues, the line state and
//   debug mode. The block accepts bytes as soon as reset is released.
module servo_command_line_parser_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] rx_char_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [2:0]      resp_code_o,
  output logic [2:0]      servo_index_o,
  output logic [7:0]      servo_degrees_o,
  output logic            debug_mode_o
);
  import scl_pkg::*;

  logic tok_valid, tok_take;
  tok_t tok;

  scl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .rx_char_i   (rx_char_i),
    .tok_valid_o (tok_valid),
    .tok_o       (tok),
    .tok_take_i  (tok_take)
  );

  scl_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tok_valid_i     (tok_valid),
    .tok_i           (tok),
    .tok_take_o      (tok_take),
    .empty           (empty),
    .pop             (pop),
    .resp_code_o     (resp_code_o),
    .servo_index_o   (servo_index_o),
    .servo_degrees_o (servo_degrees_o),
    .debug_mode_o    (debug_mode_o)
  );

endmodule
`default_nettype wire

FILE: sim/servo_command_line_parser_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_command_line_parser_top_tb
// Drives console bytes into the command line parser and checks every
// response word against a behavioral parser model kept in the bench. A
// directed set of lines comes first, then random well-formed, broken, noisy
// and overlong lines under three sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module servo_command_line_parser_top_tb;
  import scl_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] rx_char_i = 8'h00;
  logic       empty;
  logic       pop = 1'b0;
  logic [2:0] resp_code_o;
  logic [2:0] servo_index_o;
  logic [7:0] servo_degrees_o;
  logic       debug_mode_o;

  servo_command_line_parser_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .rx_char_i       (rx_char_i),
    .empty           (empty),
    .pop             (pop),
    .resp_code_o     (resp_code_o),
    .servo_index_o   (servo_index_o),
    .servo_degrees_o (servo_degrees_o),
    .debug_mode_o    (debug_mode_o)
  );

  always #5 clk_i = ~clk_i;

  logic [7:0]  rx_pending_q[$];
  resp_t       resp_expected_q[$];
  int unsigned send_idle_pct = 8;
  int unsigned recv_stall_pct = 48;
  int unsigned err_count = 0;
  int unsigned byte_count = 0;

  // parser model state
  logic [7:0]  line_buf [LINE_MAX];
  int          line_len = 0;
  bit          overflow_seen = 1'b0;
  bit          debug_on = 1'b0;

  function automatic bit word_is(input logic [7:0] b [LINE_MAX], input int n,
                                 input string w);
    if (w.len() != n) return 1'b0;
    for (int i = 0; i < n; i++) begin
      if (b[i] != w[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int unsigned scan_decimal(input logic [7:0] b [LINE_MAX],
                                               input int n, inout int p,
                                               output bit seen);
    int unsigned acc;
    acc = 0;
    seen = 1'b0;
    while (p < n && b[p] == CH_SPACE) p++;
    while (p < n && b[p] >= CH_ZERO && b[p] <= CH_NINE) begin
      seen = 1'b1;
      acc = acc * 10 + int'(b[p] - CH_ZERO);
      if (acc > NUM_SAT) acc = NUM_SAT;
      p++;
    end
    return acc;
  endfunction

  function automatic resp_t eval_line();
    logic [7:0]  b [LINE_MAX];
    logic [7:0]  c;
    resp_t       r;
    int          p;
    int unsigned id;
    int unsigned ang;
    bit          id_seen;
    bit          ang_seen;
    for (int i = 0; i < line_len; i++) begin
      c = line_buf[i];
      if (c >= CH_LC_A && c <= CH_LC_Z) c = c - CASE_OFS;
      b[i] = c;
    end
    r.code = RESP_ERROR;
    r.idx  = 3'd0;
    r.deg  = 8'd0;
    if (word_is(b, line_len, "DEBUG")) begin
      debug_on = 1'b1;
      r.code = RESP_DEBUG;
      r.idx  = DEBUG_IDX;
    end else if (debug_on && word_is(b, line_len, "RUN")) begin
      r.code = RESP_RUN;
      debug_on = 1'b0;
    end else if (line_len >= 2 && b[0] == CH_UC_S && b[1] == CH_SPACE) begin
      p = 1;
      id  = scan_decimal(b, line_len, p, id_seen);
      ang = scan_decimal(b, line_len, p, ang_seen);
      while (p < line_len && b[p] == CH_SPACE) p++;
      if (id_seen && ang_seen && p == line_len && debug_on &&
          id >= 1 && id <= ID_MAX && ang <= ANGLE_MAX) begin
        r.code = RESP_SET_OK;
        r.idx  = id[2:0];
        r.deg  = ang[7:0];
      end
    end
    r.dbg = debug_on;
    return r;
  endfunction

  task automatic parse_rx_byte(input logic [7:0] c);
    resp_t r;
    if (c == CH_CR || c == CH_LF) begin
      if (overflow_seen) begin
        overflow_seen = 1'b0;
        line_len = 0;
      end else if (line_len != 0) begin
        resp_expected_q.push_back(eval_line());
        line_len = 0;
      end
    end else if (!overflow_seen && c >= CH_SPACE && c <= CH_TILDE) begin
      if (line_len < LINE_MAX) begin
        line_buf[line_len] = c;
        line_len++;
      end else begin
        line_len = 0;
        overflow_seen = 1'b1;
        r.code = RESP_LONG;
        r.idx  = 3'd0;
        r.deg  = 8'd0;
        r.dbg  = debug_on;
        resp_expected_q.push_back(r);
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    err_count++;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) parse_rx_byte(rx_char_i);
      if (!(push && full)) begin
        if (rx_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          push      <= 1'b1;
          rx_char_i <= rx_pending_q.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    resp_t e;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (resp_expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word code=%0d idx=%0d deg=%0d dbg=%0b",
                                    resp_code_o, servo_index_o, servo_degrees_o,
                                    debug_mode_o));
        end else begin
          e = resp_expected_q.pop_front();
          if (resp_code_o !== e.code || servo_index_o !== e.idx ||
              servo_degrees_o !== e.deg || debug_mode_o !== e.dbg) begin
            report_mismatch($sformatf("got code=%0d idx=%0d deg=%0d dbg=%0b, exp %0d/%0d/%0d/%0b",
                                      resp_code_o, servo_index_o, servo_degrees_o,
                                      debug_mode_o, e.code, e.idx, e.deg, e.dbg));
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic add_byte(input logic [7:0] c);
    rx_pending_q.push_back(c);
    if (c == CH_CR || c == CH_LF || (c >= CH_SPACE && c <= CH_TILDE)) byte_count++;
  endtask

  function automatic logic [7:0] junk_byte();
    logic [7:0] c;
    do begin
      c = ($urandom_range(1) != 0) ? 8'($urandom_range(8'h1F))
                                   : 8'($urandom_range(8'hFF, 8'h7F));
    end while (c == CH_CR || c == CH_LF);
    return c;
  endfunction

  task automatic add_eol();
    case ($urandom_range(2))
      0: add_byte(CH_CR);
      1: add_byte(CH_LF);
      default: begin
        add_byte(CH_CR);
        add_byte(CH_LF);
      end
    endcase
  endtask

  task automatic add_line(input string s, input bit noisy);
    for (int i = 0; i < s.len(); i++) begin
      if (noisy && $urandom_range(19) == 0) add_byte(junk_byte());
      add_byte(s[i]);
    end
    add_eol();
  endtask

  function automatic string rand_case(input string s);
    string t;
    t = s;
    for (int i = 0; i < t.len(); i++) begin
      if (t[i] >= "A" && t[i] <= "Z" && $urandom_range(1) != 0) t[i] = t[i] + CASE_OFS;
    end
    return t;
  endfunction

  function automatic string spaces(input int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, " "};
    return s;
  endfunction

  function automatic string num_text(input int unsigned n);
    string s;
    s = $sformatf("%0d", n);
    if ($urandom_range(7) == 0) s = {spaces(0), "0", s};
    if ($urandom_range(15) == 0) s = {"00", s};
    return s;
  endfunction

  function automatic string printable_text(input int n);
    string s;
    s = spaces(n);
    for (int i = 0; i < n; i++) s[i] = 8'($urandom_range(CH_TILDE, CH_SPACE));
    return s;
  endfunction

  task automatic add_set_line(input bit corrupt);
    string       s;
    int unsigned id;
    int unsigned ang;
    int          k;
    case ($urandom_range(9))
      0:       id = 0;
      1:       id = $urandom_range(9, 5);
      2:       id = $urandom_range(999, 10);
      default: id = $urandom_range(4, 1);
    endcase
    ang = ($urandom_range(5) == 0) ? $urandom_range(999, 181) : $urandom_range(180);
    s = {($urandom_range(1) != 0) ? "S" : "s", spaces(1 + $urandom_range(2)),
         num_text(id), spaces(($urandom_range(15) == 0) ? 0 : 1 + $urandom_range(2)),
         num_text(ang), spaces(($urandom_range(3) == 0) ? $urandom_range(2) : 0)};
    if (corrupt) begin
      k = $urandom_range(s.len() - 1);
      s[k] = 8'($urandom_range(CH_TILDE, CH_SPACE));
    end
    add_line(s, 1'b1);
  endtask

  task automatic add_random_lines(input int unsigned budget);
    int unsigned stop_at;
    stop_at = byte_count + budget;
    while (byte_count < stop_at) begin
      case ($urandom_range(99)) inside
        [0:14]:  add_line(rand_case("DEBUG"), 1'b1);
        [15:22]: add_line(rand_case("RUN"), 1'b1);
        [23:62]: add_set_line(1'b0);
        [63:72]: add_set_line(1'b1);
        [73:87]: add_line(printable_text($urandom_range(22)), 1'b1);
        [88:94]: add_line(printable_text($urandom_range(35, 24)), 1'b1);
        default: add_eol();
      endcase
    end
  endtask

  task automatic drain();
    while (rx_pending_q.size() != 0 || push || resp_expected_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_line("RUN", 1'b0);
    add_line("S 1 90", 1'b0);
    add_byte(CH_CR);
    add_line("debug", 1'b0);
    add_line("S 1 0", 1'b0);
    add_line("s 4 180", 1'b0);
    add_line("S   3    45   ", 1'b0);
    add_line("S 0 10", 1'b0);
    add_line("S 5 10", 1'b0);
    add_line("S 2 181", 1'b0);
    add_line("S 999 1", 1'b0);
    add_line("S 2 0000090", 1'b0);
    add_line("S 1", 1'b0);
    add_line("S1 2", 1'b0);
    add_line("S 1 2 X", 1'b0);
    add_line("S", 1'b0);
    add_line("DEBUGX", 1'b0);
    add_line("`{~ az", 1'b0);
    add_line("ABCDEFGHIJKLMNOPQRSTUVW", 1'b0);
    add_line("ABCDEFGHIJKLMNOPQRSTUVWXYZ", 1'b0);
    add_byte(8'h00);
    add_byte(8'h7F);
    add_byte(8'hFF);
    add_byte(8'h80);
    add_byte(8'h1F);
    add_line("Run", 1'b0);
    add_line("S 2 45", 1'b0);
    add_line("abcdefghijklmnopqrstuvwxyz", 1'b0);
    add_random_lines(280);
    drain();

    send_idle_pct  = 48;
    recv_stall_pct = 8;
    add_random_lines(280);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    add_random_lines(280);
    drain();
    repeat (8) @(negedge clk_i);

    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
